FILE: src/tdsf_pkg.sv
// ----------------------------------------------------------------------------
// tdsf_pkg
// Shared types and constants for the tolerant duplicate shape filter.
// ----------------------------------------------------------------------------
package tdsf_pkg;

    localparam int MAX_KEPT_DEF = 64;
    localparam int EPS_W        = 20;
    localparam int KIND_W       = 3;
    localparam int LAYER_W      = 8;
    localparam int LWIDTH_W     = 31;
    localparam int COORD_W      = 32;
    localparam int NUM_W        = 16;
    localparam int VERDICT_W    = 2;
    localparam int ATTR_W       = KIND_W + LAYER_W + LWIDTH_W + 1;
    localparam int ENTRY_W      = 6 * COORD_W + ATTR_W;

    localparam logic [KIND_W-1:0] KIND_SEGMENT   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_RECTANGLE = 3'd1;
    localparam logic [KIND_W-1:0] KIND_ARC       = 3'd2;
    localparam logic [KIND_W-1:0] KIND_CIRCLE    = 3'd3;
    localparam logic [KIND_W-1:0] KIND_OTHER     = 3'd4;

    localparam logic [VERDICT_W-1:0] VERDICT_KEEP = 2'd0;
    localparam logic [VERDICT_W-1:0] VERDICT_NULL = 2'd1;
    localparam logic [VERDICT_W-1:0] VERDICT_DUP  = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0]   shape_kind;
        logic [LAYER_W-1:0]  layer;
        logic [LWIDTH_W-1:0] line_width;
        logic signed [COORD_W-1:0] start_x;
        logic signed [COORD_W-1:0] start_y;
        logic signed [COORD_W-1:0] end_x;
        logic signed [COORD_W-1:0] end_y;
        logic                has_midpoint;
        logic signed [COORD_W-1:0] mid_x;
        logic signed [COORD_W-1:0] mid_y;
        logic                last_shape;
    } t_shape;

    typedef struct packed {
        logic [NUM_W-1:0]     shape_number;
        logic [VERDICT_W-1:0] verdict;
        logic                 table_full;
    } t_result;

    // one stored table row
    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [LAYER_W-1:0]  layer;
        logic [LWIDTH_W-1:0] line_width;
        logic                has_mid;
        logic [COORD_W-1:0]  sx, sy, ex, ey, mx, my;
    } t_entry;

    // |a-b| <= eps on one axis
    function automatic logic axis_close(input logic [COORD_W-1:0] a,
                                        input logic [COORD_W-1:0] b,
                                        input logic [EPS_W-1:0] eps);
        logic signed [COORD_W:0] d;
        logic [COORD_W:0] m;
        d = $signed({a[COORD_W-1], a}) - $signed({b[COORD_W-1], b});
        m = d[COORD_W] ? (~d + 1'b1) : d;
        return m <= {{(COORD_W+1-EPS_W){1'b0}}, eps};
    endfunction

endpackage

FILE: src/tdsf_if.sv
// ----------------------------------------------------------------------------
// tdsf_if
// Valid/ready channel carrying one payload of type T.
// ----------------------------------------------------------------------------
interface tdsf_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: src/tdsf_ram.sv
// ----------------------------------------------------------------------------
// tdsf_ram
// Generic single-port-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tdsf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end
    assign o_rdata = r_rdata;
endmodule

FILE: src/tdsf_cmp.sv
// ----------------------------------------------------------------------------
// tdsf_cmp
// Shared match unit: compares the current shape with one table row.
// ----------------------------------------------------------------------------
module tdsf_cmp
    import tdsf_pkg::*;
(
    input  t_entry           i_cur,
    input  t_entry           i_row,
    input  logic [EPS_W-1:0] i_eps,
    output logic             o_match
);
    logic ss, ee, se, es, mm, attr_eq, mid_ok;

    always_comb begin
        ss = axis_close(i_row.sx, i_cur.sx, i_eps) && axis_close(i_row.sy, i_cur.sy, i_eps);
        ee = axis_close(i_row.ex, i_cur.ex, i_eps) && axis_close(i_row.ey, i_cur.ey, i_eps);
        se = axis_close(i_row.sx, i_cur.ex, i_eps) && axis_close(i_row.sy, i_cur.ey, i_eps);
        es = axis_close(i_row.ex, i_cur.sx, i_eps) && axis_close(i_row.ey, i_cur.sy, i_eps);
        mm = axis_close(i_row.mx, i_cur.mx, i_eps) && axis_close(i_row.my, i_cur.my, i_eps);
        attr_eq = (i_row.kind == i_cur.kind) && (i_row.layer == i_cur.layer)
               && (i_row.line_width == i_cur.line_width);
        mid_ok = (!i_row.has_mid && !i_cur.has_mid) || (i_row.has_mid && i_cur.has_mid && mm);
        o_match = 1'b0;
        if (attr_eq) begin
            if (i_cur.kind == KIND_SEGMENT || i_cur.kind == KIND_RECTANGLE
                || i_cur.kind == KIND_CIRCLE) begin
                o_match = (ss && ee) || (se && es);
            end else if (i_cur.kind == KIND_ARC) begin
                o_match = mid_ok && ss && ee && (i_row.has_mid == i_cur.has_mid);
            end
        end
    end
endmodule

FILE: src/tolerant_duplicate_shape_filter.sv
// ----------------------------------------------------------------------------
// tolerant_duplicate_shape_filter
// Streaming duplicate/null shape filter with epsilon-tolerant point compare.
// ----------------------------------------------------------------------------
//  channel   dir  payload
//  i_shape   in   t_shape  (one board shape per request)
//  o_result  out  t_result (one verdict per shape)
//  i_cfg     in   epsilon, 20 bit
//
//  After acceptance, table rows stream one per cycle out of the RAM, whose
//  read data is registered, into the shared match unit; a finish state then
//  posts the verdict. A duplicate stops the scan early; a null shape posts
//  its result the next cycle.
//  Reset clears the count, arrival counter and epsilon; no clearing pass.
//  Input is held off while a shape is in work or its result is not taken, so
//  no new shape is accepted before the previous verdict has been taken.
module tolerant_duplicate_shape_filter
    import tdsf_pkg::*;
#(
    parameter int MAX_KEPT = MAX_KEPT_DEF
) (
    input logic i_clk,
    input logic i_rst_n,
    tdsf_if.sink   i_shape,
    tdsf_if.source o_result,
    tdsf_if.sink   i_cfg
);
    localparam int AW = $clog2(MAX_KEPT);
    localparam int CW = $clog2(MAX_KEPT + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]           r_state;
    logic [EPS_W-1:0]     r_eps;
    logic [CW-1:0]        r_count;
    logic [CW-1:0]        r_idx;    // row being read; its data is registered in the RAM
    logic                 r_rd_vld;
    logic [NUM_W-1:0]     r_arrival;
    t_entry               r_cur;
    logic                 r_last;
    logic                 r_out_vld;
    t_result              r_out;
    logic                 r_dup;

    t_entry cur_in, row;
    logic   match, we;
    logic [AW-1:0] raddr;

    always_comb begin
        cur_in.kind       = i_shape.data.shape_kind;
        cur_in.layer      = i_shape.data.layer;
        cur_in.line_width = i_shape.data.line_width;
        cur_in.has_mid    = i_shape.data.has_midpoint;
        cur_in.sx = i_shape.data.start_x;
        cur_in.sy = i_shape.data.start_y;
        cur_in.ex = i_shape.data.end_x;
        cur_in.ey = i_shape.data.end_y;
        cur_in.mx = i_shape.data.mid_x;
        cur_in.my = i_shape.data.mid_y;
    end

    assign i_shape.ready = (r_state == S_IDLE) && !r_out_vld;
    assign i_cfg.ready   = 1'b1;
    assign o_result.valid = r_out_vld;
    assign o_result.data  = r_out;

    assign raddr = r_idx[AW-1:0];
    assign we = (r_state == S_DONE) && !r_dup && (r_count < CW'(MAX_KEPT));

    tdsf_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_KEPT)) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(r_count[AW-1:0]),
        .i_wdata(r_cur),
        .i_raddr(raddr),
        .o_rdata(row)
    );

    tdsf_cmp u_cmp (.i_cur(r_cur), .i_row(row), .i_eps(r_eps), .o_match(match));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_eps     <= '0;
            r_count   <= '0;
            r_idx     <= '0;
            r_rd_vld  <= 1'b0;
            r_arrival <= '0;
            r_out_vld <= 1'b0;
            r_dup     <= 1'b0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                r_eps <= i_cfg.data;
            end
            if (o_result.valid && o_result.ready) begin
                r_out_vld <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_shape.valid && i_shape.ready) begin
                        r_cur  <= cur_in;
                        r_last <= i_shape.data.last_shape;
                        r_dup  <= 1'b0;
                        r_idx  <= '0;
                        r_rd_vld <= 1'b0;
                        if (i_shape.data.shape_kind <= KIND_CIRCLE
                            && axis_close(i_shape.data.start_x, i_shape.data.end_x, r_eps)
                            && axis_close(i_shape.data.start_y, i_shape.data.end_y, r_eps))
                        begin
                            r_out.shape_number <= r_arrival;
                            r_out.verdict      <= VERDICT_NULL;
                            r_out.table_full   <= 1'b0;
                            r_out_vld          <= 1'b1;
                            if (i_shape.data.last_shape) begin
                                r_arrival <= '0;
                                r_count   <= '0;
                            end else if (r_arrival != '1) begin
                                r_arrival <= r_arrival + 1'b1;
                            end
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    // read address runs one row ahead of the compared row
                    if (r_rd_vld && match && (r_cur.kind <= KIND_CIRCLE)) begin
                        r_dup   <= 1'b1;
                        r_state <= S_DONE;
                    end else if (r_idx >= r_count) begin
                        r_state <= S_DONE;
                    end else begin
                        r_idx    <= r_idx + 1'b1;
                        r_rd_vld <= 1'b1;
                    end
                    if (r_idx >= r_count && !(r_rd_vld && match)) begin
                        r_rd_vld <= 1'b0;
                    end
                end
                S_DONE: begin
                    r_out.shape_number <= r_arrival;
                    r_out.verdict      <= r_dup ? VERDICT_DUP : VERDICT_KEEP;
                    r_out.table_full   <= !r_dup && (r_count >= CW'(MAX_KEPT));
                    r_out_vld          <= 1'b1;
                    r_state            <= S_IDLE;
                    if (r_last) begin
                        r_arrival <= '0;
                        r_count   <= '0;
                    end else begin
                        if (r_arrival != '1) begin
                            r_arrival <= r_arrival + 1'b1;
                        end
                        if (we) begin
                            r_count <= r_count + 1'b1;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    property p_count_bound;
        @(posedge i_clk) disable iff (!i_rst_n) r_count <= CW'(MAX_KEPT);
    endproperty
    a_count_bound: assert property (p_count_bound) else $error("table count overflow");

    a_busy_no_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !i_shape.ready) else $error("ready while busy");

    a_done_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |=> r_out_vld) else $error("result not posted");

    a_full_is_keep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out.table_full) |-> (r_out.verdict == VERDICT_KEEP))
        else $error("full flag on non-keep");
endmodule

FILE: sim/tdsf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdsf_checker
// Watches shape, result and epsilon channels, predicts each verdict from its
// own copy of the kept-shape table and compares results in order.
// ----------------------------------------------------------------------------
module tdsf_checker
    import tdsf_pkg::*;
#(
    parameter int MAX_KEPT = MAX_KEPT_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_shape_valid,
    input  logic    i_shape_ready,
    input  t_shape  i_shape_data,
    input  logic    i_res_valid,
    input  logic    i_res_ready,
    input  t_result i_res_data,
    input  logic    i_cfg_valid,
    input  logic    i_cfg_ready,
    input  logic [EPS_W-1:0] i_cfg_data,
    output int      o_errors,
    output int      o_pending
);

    logic [EPS_W-1:0] eps_model;
    t_entry           kept_tbl [MAX_KEPT];
    int               kept_n;
    logic [NUM_W-1:0] arrival_n;
    t_result          verdict_q [$];

    function automatic logic near(input logic [COORD_W-1:0] ax, ay, bx, by);
        longint dx, dy;
        dx = longint'($signed(ax)) - longint'($signed(bx));
        dy = longint'($signed(ay)) - longint'($signed(by));
        if (dx < 0) dx = -dx;
        if (dy < 0) dy = -dy;
        return (dx <= longint'(eps_model)) && (dy <= longint'(eps_model));
    endfunction

    function automatic logic same_shape(input t_entry k, input t_shape s);
        logic mid_ok;
        if (k.kind != s.shape_kind || k.layer != s.layer || k.line_width != s.line_width)
            return 1'b0;
        if (s.shape_kind == KIND_SEGMENT || s.shape_kind == KIND_RECTANGLE ||
            s.shape_kind == KIND_CIRCLE)
            return (near(k.sx, k.sy, s.start_x, s.start_y) &&
                    near(k.ex, k.ey, s.end_x, s.end_y)) ||
                   (near(k.sx, k.sy, s.end_x, s.end_y) &&
                    near(k.ex, k.ey, s.start_x, s.start_y));
        if (s.shape_kind == KIND_ARC) begin
            mid_ok = (!k.has_mid && !s.has_midpoint) ||
                     (k.has_mid && s.has_midpoint && near(k.mx, k.my, s.mid_x, s.mid_y));
            return mid_ok && near(k.sx, k.sy, s.start_x, s.start_y) &&
                   near(k.ex, k.ey, s.end_x, s.end_y);
        end
        return 1'b0;
    endfunction

    task automatic predict_verdict(input t_shape s);
        t_result r;
        t_entry  e;
        r = '0;
        r.verdict = VERDICT_KEEP;
        r.shape_number = arrival_n;
        if (s.shape_kind <= KIND_CIRCLE && near(s.start_x, s.start_y, s.end_x, s.end_y)) begin
            r.verdict = VERDICT_NULL;
        end else begin
            for (int i = 0; i < kept_n; i++)
                if (r.verdict == VERDICT_KEEP && same_shape(kept_tbl[i], s))
                    r.verdict = VERDICT_DUP;
            if (r.verdict == VERDICT_KEEP) begin
                if (kept_n < MAX_KEPT) begin
                    e.kind = s.shape_kind; e.layer = s.layer;
                    e.line_width = s.line_width; e.has_mid = s.has_midpoint;
                    e.sx = s.start_x; e.sy = s.start_y; e.ex = s.end_x; e.ey = s.end_y;
                    e.mx = s.mid_x; e.my = s.mid_y;
                    kept_tbl[kept_n] = e;
                    kept_n++;
                end else begin
                    r.table_full = 1'b1;
                end
            end
        end
        verdict_q.insert(verdict_q.size(), r);
        if (arrival_n != '1) arrival_n++;
        if (s.last_shape) begin
            kept_n = 0;
            arrival_n = '0;
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            eps_model <= '0;
            kept_n = 0;
            arrival_n = '0;
            o_errors = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) eps_model <= i_cfg_data;
            if (i_shape_valid && i_shape_ready) predict_verdict(i_shape_data);
            if (i_res_valid && i_res_ready) begin
                if (verdict_q.size() == 0) begin
                    if (o_errors < 10) $display("unexpected result %p", i_res_data);
                    o_errors++;
                end else begin
                    want = verdict_q.pop_front();
                    if (want !== i_res_data) begin
                        if (o_errors < 10)
                            $display({"mismatch: expected num=%0d v=%0d f=%0d,",
                                      " got num=%0d v=%0d f=%0d"},
                                want.shape_number, want.verdict, want.table_full,
                                i_res_data.shape_number, i_res_data.verdict,
                                i_res_data.table_full);
                        o_errors++;
                    end
                end
            end
        end
        o_pending <= verdict_q.size();
    end

endmodule

FILE: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives shapes and epsilon settings through idle/stall phases and reports
// the checker's verdict.
// ----------------------------------------------------------------------------
module tb;
    import tdsf_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   errors, pending;
    int   sender_idle, recv_stall;
    logic hold_req = 1'b0;
    logic hold_taken = 1'b0;
    int   hold_left = 0;
    longint cycles = 0;

    tdsf_if #(.T(t_shape))           shape_if ();
    tdsf_if #(.T(t_result))          res_if ();
    tdsf_if #(.T(logic [EPS_W-1:0])) cfg_if ();

    tolerant_duplicate_shape_filter uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_shape(shape_if.sink), .o_result(res_if.source), .i_cfg(cfg_if.sink)
    );

    tdsf_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_shape_valid(shape_if.valid), .i_shape_ready(shape_if.ready),
        .i_shape_data(shape_if.data),
        .i_res_valid(res_if.valid), .i_res_ready(res_if.ready),
        .i_res_data(res_if.data),
        .i_cfg_valid(cfg_if.valid), .i_cfg_ready(cfg_if.ready),
        .i_cfg_data(cfg_if.data),
        .o_errors(errors), .o_pending(pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // receiver: random stall, or one long hold-off when requested
    always @(posedge i_clk) begin
        if (hold_req && !hold_taken) begin
            hold_taken   <= 1'b1;
            hold_left    <= 600;
            res_if.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left    <= hold_left - 1;
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= ($urandom_range(99) >= recv_stall);
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > 2000000) begin
            $display("tolerant_duplicate_shape_filter test failed");
            $finish;
        end
    end

    t_shape prev_pool [$];

    function automatic logic [COORD_W-1:0] jitter(input logic [COORD_W-1:0] v,
                                                  input int amt);
        return v + COORD_W'($signed($urandom_range(2 * amt) - amt));
    endfunction

    function automatic t_shape rand_shape(input logic [EPS_W-1:0] eps);
        t_shape s;
        int     amt;
        logic [9*32-1:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
               $urandom, $urandom};
        s = raw[$bits(t_shape)-1:0];
        amt = (eps > 1000) ? 1000 : int'(eps) + 1;
        s.shape_kind = ($urandom_range(9) == 0) ? KIND_W'($urandom_range(7, 4))
                                                : KIND_W'($urandom_range(3));
        if ($urandom_range(1)) begin
            s.layer = LAYER_W'($urandom_range(3));
            s.line_width = LWIDTH_W'($urandom_range(3));
        end
        if ($urandom_range(9) < 6 && prev_pool.size() > 0) begin
            // near-copy of an earlier shape, sometimes swapped
            s = prev_pool[$urandom_range(prev_pool.size() - 1)];
            s.start_x = jitter(s.start_x, amt); s.start_y = jitter(s.start_y, amt);
            s.end_x = jitter(s.end_x, amt);     s.end_y = jitter(s.end_y, amt);
            s.mid_x = jitter(s.mid_x, amt);     s.mid_y = jitter(s.mid_y, amt);
            if ($urandom_range(3) == 0) begin
                s.start_x = prev_pool[0].end_x; s.start_y = prev_pool[0].end_y;
            end
            if ($urandom_range(2) == 0) {s.start_x, s.start_y, s.end_x, s.end_y} =
                {s.end_x, s.end_y, s.start_x, s.start_y};
            if ($urandom_range(7) == 0) s.has_midpoint = ~s.has_midpoint;
        end else if ($urandom_range(9) == 0) begin
            s.end_x = jitter(s.start_x, amt);
            s.end_y = jitter(s.start_y, amt);
        end
        s.last_shape = ($urandom_range(59) == 0);
        return s;
    endfunction

    // valid stays up between back-to-back requests; drain() drops it
    task automatic send_shape(input t_shape s);
        while ($urandom_range(99) < sender_idle) begin
            shape_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        shape_if.valid <= 1'b1;
        shape_if.data <= s;
        @(posedge i_clk);
        while (!shape_if.ready) @(posedge i_clk);
        prev_pool.insert(prev_pool.size(), s);
        if (prev_pool.size() > 16) void'(prev_pool.pop_front());
        if (s.last_shape) prev_pool.delete();
    endtask

    task automatic drain();
        shape_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic set_eps(input logic [EPS_W-1:0] v);
        cfg_if.valid <= 1'b1;
        cfg_if.data <= v;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        cfg_if.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic directed(input logic [KIND_W-1:0] k, input logic [COORD_W-1:0] a,
                            input logic [COORD_W-1:0] b, input logic hm,
                            input logic lst);
        t_shape s;
        s = '0;
        s.shape_kind = k; s.layer = 8'hFF; s.line_width = '1;
        s.start_x = a; s.start_y = b; s.end_x = b; s.end_y = a;
        s.has_midpoint = hm; s.mid_x = a; s.mid_y = b; s.last_shape = lst;
        send_shape(s);
    endtask

    initial begin
        logic [EPS_W-1:0] eps_set [5];
        t_shape s;
        shape_if.valid = 1'b0;
        shape_if.data = '0;
        cfg_if.valid = 1'b0;
        cfg_if.data = '0;
        eps_set = '{20'd0, 20'hFFFFF, 20'd5, 20'd1000, 20'd37};
        sender_idle = 0;
        recv_stall = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, every kind, nulls, swaps, arcs with/without mid
        directed(KIND_SEGMENT, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 1'b0);
        directed(KIND_SEGMENT, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 1'b0);
        directed(KIND_SEGMENT, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 1'b0);
        directed(KIND_RECTANGLE, 32'd5, 32'd5, 1'b0, 1'b0);
        directed(KIND_RECTANGLE, 32'd1, 32'd9, 1'b0, 1'b0);
        directed(KIND_CIRCLE, 32'd9, 32'd1, 1'b0, 1'b0);
        directed(KIND_CIRCLE, 32'd9, 32'd1, 1'b0, 1'b0);
        directed(KIND_ARC, 32'd3, 32'd7, 1'b1, 1'b0);
        directed(KIND_ARC, 32'd3, 32'd7, 1'b1, 1'b0);
        directed(KIND_ARC, 32'd3, 32'd7, 1'b0, 1'b0);
        directed(KIND_ARC, 32'd7, 32'd3, 1'b1, 1'b0);
        directed(KIND_OTHER, 32'd2, 32'd2, 1'b0, 1'b0);
        directed(KIND_OTHER, 32'd2, 32'd2, 1'b0, 1'b0);
        directed(3'd7, 32'hFFFF_FFFF, 32'd0, 1'b1, 1'b1);
        drain();
        set_eps(20'hFFFFF);
        directed(KIND_SEGMENT, 32'd0, 32'd1000000, 1'b0, 1'b0);
        directed(KIND_SEGMENT, 32'd0, 32'd1048576, 1'b0, 1'b0);
        directed(KIND_ARC, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 1'b1);
        drain();

        // fill the table past capacity with 66 other-kind shapes, then four segments
        set_eps(20'd0);
        for (int i = 0; i < 70; i++) begin
            s = rand_shape(20'd0);
            s.shape_kind = (i < 66) ? KIND_OTHER : KIND_SEGMENT;
            s.last_shape = (i == 69);
            send_shape(s);
        end
        drain();

        for (int ph = 0; ph < 5; ph++) begin
            set_eps(eps_set[ph]);
            case (ph)
                1: begin sender_idle = 81; recv_stall = 0; end
                2: begin sender_idle = 0; recv_stall = 81; end
                3: begin sender_idle = 8; recv_stall = 8; end
                default: begin sender_idle = 0; recv_stall = 0; end
            endcase
            for (int i = 0; i < 150; i++) begin
                if (ph == 0 && i == 20) hold_req = 1'b1;
                send_shape(rand_shape(eps_set[ph]));
            end
            // sender waits until every verdict is back
            drain();
        end

        if (errors == 0)
            $display("tolerant_duplicate_shape_filter test passed");
        else
            $display("tolerant_duplicate_shape_filter test failed");
        $finish;
    end

endmodule
